@@ sv/pctb_pkg.sv @@
// shared constants, register codes and state type of the per-client token bucket
package pctb_pkg;

   localparam int CLIENTS       = 256;
   localparam int FRACTION_BITS = 16;

   localparam int CLIENT_INDEX_W = 8;
   localparam int NOW_TIME_W     = 32;
   localparam int MAX_TOKENS_W   = 8;
   localparam int REFILL_RATE_W  = 24;
   localparam int TOKENS_LEFT_W  = 8;
   localparam int CSR_DATA_W     = 24;
   localparam int CSR_INDEX_W    = 1;

   localparam int CLIENT_W     = $clog2(CLIENTS);
   localparam int CLIENT_EXT_W = ((CLIENT_W > CLIENT_INDEX_W) ? CLIENT_W : CLIENT_INDEX_W) + 1;
   localparam int LEVEL_W      = MAX_TOKENS_W + FRACTION_BITS;
   localparam int PROD_W       = NOW_TIME_W + REFILL_RATE_W;
   localparam int SUM_W        = PROD_W + 1;
   localparam int ENTRY_W      = LEVEL_W + NOW_TIME_W;

   localparam logic [MAX_TOKENS_W-1:0]  MAX_TOKENS_RESET  = 8'd3;
   localparam logic [REFILL_RATE_W-1:0] REFILL_RATE_RESET = 24'd65536;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_TOKENS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_REFILL_RATE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_UPD  = 3'b100
   } state_type;

endpackage

@@ sv/per_client_token_bucket.sv @@
// per-client token bucket rate limiter with bucket state in one synchronous memory
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_client_index, req_now_time
//   rsp      out        rsp_valid / rsp_ready   rsp_allowed, rsp_tokens_left
//   csr      in         csr_write_en            csr_index, csr_wdata
//
// each item goes through accept with memory read, 32x24 refill multiply, then
// add/saturate/take token with memory write-back; the next item enters after that
// one item at a time, so no forwarding is needed on the memory
// reset clears the seen bits and the control state at once; no clearing pass
// a stalled rsp beat holds the update stage; a new req beat is still taken while a
// finished beat waits on rsp
module per_client_token_bucket (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pctb_pkg::CLIENT_INDEX_W-1:0]  req_client_index,
   input  logic [pctb_pkg::NOW_TIME_W-1:0]      req_now_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_allowed,
   output logic [pctb_pkg::TOKENS_LEFT_W-1:0]   rsp_tokens_left,
   input  logic                                 csr_write_en,
   input  logic [pctb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pctb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pctb_pkg::*;

   state_type state_ff, state_in;

   logic [MAX_TOKENS_W-1:0]  max_tokens_ff;
   logic [REFILL_RATE_W-1:0] refill_rate_ff;

   logic [CLIENTS-1:0] seen_ff, seen_in;

   logic [ENTRY_W-1:0] mem [CLIENTS];
   logic [ENTRY_W-1:0] mem_rd_ff;

   logic [CLIENT_W-1:0]   addr_ff;
   logic [NOW_TIME_W-1:0] now_ff;
   logic                  hit_seen_ff;
   logic                  in_range_ff;

   logic [PROD_W-1:0]  product_ff;
   logic [LEVEL_W-1:0] base_level_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_allowed_ff;
   logic [TOKENS_LEFT_W-1:0] rsp_tokens_ff;

   logic                    req_take;
   logic                    upd_go;
   logic [CLIENT_EXT_W-1:0] client_ext;
   logic                    client_ok;
   logic [CLIENT_W-1:0]     client_addr;
   logic [LEVEL_W-1:0]      cap_fixed;
   logic [LEVEL_W-1:0]      one_fixed;
   logic [NOW_TIME_W-1:0]   elapsed;
   logic [PROD_W-1:0]       product_c;
   logic [SUM_W-1:0]        sum_c;
   logic [LEVEL_W-1:0]      sat_level;
   logic                    allow_c;
   logic [LEVEL_W-1:0]      new_level;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_take    = req_valid && req_ready;
   assign client_ext  = CLIENT_EXT_W'(req_client_index);
   assign client_ok   = (client_ext < CLIENT_EXT_W'(CLIENTS));
   assign client_addr = client_ext[CLIENT_W-1:0];

   assign cap_fixed = {max_tokens_ff, {FRACTION_BITS{1'b0}}};
   assign one_fixed = LEVEL_W'(1) << FRACTION_BITS;

   // a first-time client starts full with zero elapsed time
   assign elapsed   = hit_seen_ff ? (now_ff - mem_rd_ff[NOW_TIME_W-1:0]) : '0;
   assign product_c = PROD_W'(elapsed) * PROD_W'(refill_rate_ff);

   assign sum_c     = SUM_W'(product_ff) + SUM_W'(base_level_ff);
   assign sat_level = (sum_c > SUM_W'(cap_fixed)) ? cap_fixed : sum_c[LEVEL_W-1:0];
   assign allow_c   = (sat_level >= one_fixed);
   assign new_level = allow_c ? (sat_level - one_fixed) : sat_level;

   // update stage retires when the output register is free or being drained
   assign upd_go = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (upd_go) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      seen_in = seen_ff;
      if (upd_go && in_range_ff) seen_in[addr_ff] = 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_go) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         max_tokens_ff  <= MAX_TOKENS_RESET;
         refill_rate_ff <= REFILL_RATE_RESET;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_MAX_TOKENS:  max_tokens_ff  <= csr_wdata[MAX_TOKENS_W-1:0];
               REG_REFILL_RATE: refill_rate_ff <= csr_wdata[REFILL_RATE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // bucket memory: read at accept, written back at update
   always_ff @(posedge clock) begin
      if (req_take) mem_rd_ff <= mem[client_addr];
      if (upd_go && in_range_ff) mem[addr_ff] <= {new_level, now_ff};
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff     <= client_addr;
         now_ff      <= req_now_time;
         hit_seen_ff <= seen_ff[client_addr];
         in_range_ff <= client_ok;
      end
      if (state_ff == S_MUL) begin
         product_ff    <= product_c;
         base_level_ff <= hit_seen_ff ? mem_rd_ff[ENTRY_W-1:NOW_TIME_W] : cap_fixed;
      end
      if (upd_go) begin
         rsp_allowed_ff <= in_range_ff && allow_c;
         rsp_tokens_ff  <= in_range_ff ? new_level[LEVEL_W-1:FRACTION_BITS] : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_allowed     = rsp_allowed_ff;
   assign rsp_tokens_left = rsp_tokens_ff;

   // an admitted beat always leaves less than a full bucket
   a_allowed_below_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_allowed) |-> (rsp_tokens_left < max_tokens_ff))
      else $error("admitted beat reports a full bucket");

   // only one item in flight
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready ##1 !req_ready)
      else $error("req beat taken while an item is in flight");

   // write-back marks the client as seen
   a_seen_after_update: assert property (@(posedge clock) disable iff (reset)
      (upd_go && in_range_ff) |=> seen_ff[$past(addr_ff)])
      else $error("client not marked seen after update");

endmodule
